FILE: src/lru_k_frame_replacer_core_defines.svh
// ---------------------------------------------------------------------------
// LRU-K replacer assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and reset by rst_ni.
// ---------------------------------------------------------------------------
`ifndef LRU_K_FRAME_REPLACER_CORE_DEFINES_SVH
`define LRU_K_FRAME_REPLACER_CORE_DEFINES_SVH
`ifndef SYNTH
`define LKR_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) prop) else $error(msg);
`define LKR_ASSERT_IMP(lbl, a, b, msg) `LKR_ASSERT(lbl, (a) |-> (b), msg)
`else
`define LKR_ASSERT(lbl, prop, msg)
`define LKR_ASSERT_IMP(lbl, a, b, msg)
`endif
`endif

FILE: src/lkr_pkg.sv
// ---------------------------------------------------------------------------
// LRU-K replacer package
// Types, codes and fixed widths shared by the replacer modules.
// ---------------------------------------------------------------------------
package lkr_pkg;

  // Sized for the largest supported MAX_K of 16.
  localparam int TALLY_W = 5;
  localparam int HEAD_W  = 4;

  localparam logic CFG_ACTIVE = 1'b0;
  localparam logic CFG_K      = 1'b1;

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_SETEV  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EVICT  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ACCESS,
    CMD_SET,
    CMD_CLEAR,
    CMD_UNTRACK
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_TAIL,
    ST_FIN,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic               tracked;
    logic               in_cache;
    logic               evictable;
    logic [TALLY_W-1:0] tally;
    logic [HEAD_W-1:0]  head;
  } cell_t;

  typedef struct packed {
    cmd_e               kind;
    logic [TALLY_W-1:0] keff;
  } cell_cmd_t;

endpackage

FILE: src/lru_k_frame_replacer_core.sv
// ---------------------------------------------------------------------------
// LRU-K frame replacer core
// Tracks frame accesses and picks eviction victims by the LRU-K rule.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Transfer when           Contents
//   s_axis    in         tvalid && tready        one operation
//   m_axis    out        tvalid && tready        one result per operation
//   cfg       in         cfg_we_i high           active frames, k value
//
// Access, set evictable and remove pass through the execute and done states; the
// result is registered on leaving done, and the next input is taken back in idle.
// Evict passes through execute, scan, tail, finish and done: in the scan the
// frame cells rotate once through the chain, one frame a cycle, while each frame's
// key is read from the stamp RAM.
// Reset clears all control state at once; the stamp RAM needs no clearing,
// since only entries written since a frame became tracked are ever read.
// A result waits in the output register while the next operation is taken.
// ---------------------------------------------------------------------------
`include "lru_k_frame_replacer_core_defines.svh"

module lru_k_frame_replacer_core import lkr_pkg::*; #(
  parameter int N_FRAMES   = 64,
  parameter int MAX_K      = 8,
  parameter int STAMP_BITS = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // frame[5:0], make_evictable[6], zero[7]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // evicted_valid[0], evicted_frame[6:1],
                                      // evictable_count[13:7], zero[15:14]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i
);

  localparam int FW = (N_FRAMES > 1) ? $clog2(N_FRAMES) : 1;
  localparam int DEPTH = N_FRAMES * MAX_K;
  localparam int AW = $clog2(DEPTH);
  localparam int CWR = $clog2(N_FRAMES + 1);
  localparam int CW = (CWR > 7) ? CWR : 7;
  localparam int XW = FW + 6;

  st_e                   state_q, state_d;
  op_e                   op_q, op_d;
  logic [5:0]            frame_q, frame_d;
  logic                  mark_q, mark_d;
  logic [6:0]            active_q;
  logic [3:0]            k_q;
  logic [STAMP_BITS-1:0] stamp_q, stamp_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [FW-1:0]         scan_q, scan_d;
  logic                  p_valid_q, p_valid_d, p_hist_q, p_hist_d;
  logic [FW-1:0]         p_frame_q, p_frame_d;
  logic                  bh_found_q, bh_found_d, bc_found_q, bc_found_d;
  logic [STAMP_BITS-1:0] bh_key_q, bh_key_d, bc_key_q, bc_key_d;
  logic [FW-1:0]         bh_frame_q, bh_frame_d, bc_frame_q, bc_frame_d;
  logic                  res_valid_q, res_valid_d;
  logic [FW-1:0]         res_frame_q, res_frame_d;
  logic                  out_valid_q, out_valid_d;
  logic [15:0]           out_data_q, out_data_d;

  cell_t                 cell_q [N_FRAMES];
  logic [N_FRAMES-1:0]   sel;
  logic                  shift;
  cell_cmd_t             cmd;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [STAMP_BITS-1:0] ram_rdata;

  logic [XW-1:0]         frame_x, victim_x;
  logic [FW-1:0]         f_idx, victim;
  logic                  in_range, found;
  cell_t                 cur, head;
  logic [5:0]            idx_sum;
  logic [HEAD_W-1:0]     key_idx;
  logic [TALLY_W-1:0]    keff;
  logic                  can_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 7'd64;
      k_q      <= 4'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACTIVE: active_q <= cfg_wdata_i;
        CFG_K:      k_q      <= cfg_wdata_i[3:0];
        default:    active_q <= active_q;
      endcase
    end
  end

  // Effective k: zero acts as one, anything above MAX_K acts as MAX_K.
  always_comb begin
    if (k_q == 4'd0) begin
      keff = TALLY_W'(1);
    end else if ({1'b0, k_q} > TALLY_W'(MAX_K)) begin
      keff = TALLY_W'(MAX_K);
    end else begin
      keff = TALLY_W'(k_q);
    end
  end

  // The frame cell chain; cell i takes cell i+1 on a shift, the last takes cell 0.
  for (genvar i = 0; i < N_FRAMES; i++) begin : g_cell
    lkr_cell #(.MAX_K(MAX_K)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .nb_i    (cell_q[(i + 1) % N_FRAMES]),
      .sel_i   (sel[i]),
      .cmd_i   (cmd),
      .state_o (cell_q[i])
    );
  end

  lkr_ram #(.WIDTH(STAMP_BITS), .DEPTH(DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (stamp_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign frame_x  = {{FW{1'b0}}, frame_q};
  assign f_idx    = frame_x[FW-1:0];
  assign in_range = frame_x < XW'(N_FRAMES);
  assign cur      = cell_q[f_idx];
  assign head     = cell_q[0];
  assign found    = bh_found_q || bc_found_q;
  assign victim   = bh_found_q ? bh_frame_q : bc_frame_q;
  assign victim_x = {6'd0, res_frame_q};
  assign can_out  = !out_valid_q || m_axis_tready;

  // Key slot of the frame at the chain head: tally entries back from head.
  always_comb begin
    idx_sum = {2'b00, head.head} + 6'(MAX_K) - {1'b0, head.tally};
    key_idx = (idx_sum >= 6'(MAX_K)) ? HEAD_W'(idx_sum - 6'(MAX_K)) : HEAD_W'(idx_sum);
  end

  assign ram_raddr = AW'(scan_q) * AW'(MAX_K) + AW'(key_idx);
  assign ram_waddr = AW'(f_idx) * AW'(MAX_K) + (cur.tracked ? AW'(cur.head) : '0);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    frame_d     = frame_q;
    mark_d      = mark_q;
    stamp_d     = stamp_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    p_valid_d   = 1'b0;
    p_hist_d    = !head.in_cache;
    p_frame_d   = scan_q;
    bh_found_d  = bh_found_q;
    bh_key_d    = bh_key_q;
    bh_frame_d  = bh_frame_q;
    bc_found_d  = bc_found_q;
    bc_key_d    = bc_key_q;
    bc_frame_d  = bc_frame_q;
    res_valid_d = res_valid_q;
    res_frame_d = res_frame_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    sel         = '0;
    shift       = 1'b0;
    cmd.kind    = CMD_NONE;
    cmd.keff    = keff;
    ram_we      = 1'b0;
    s_axis_tready = 1'b0;

    // Compare stage of the scan, one RAM read behind the chain head.
    if (p_valid_q) begin
      if (p_hist_q) begin
        if (!bh_found_q || ram_rdata < bh_key_q) begin
          bh_found_d = 1'b1;
          bh_key_d   = ram_rdata;
          bh_frame_d = p_frame_q;
        end
      end else if (!bc_found_q || ram_rdata < bc_key_q) begin
        bc_found_d = 1'b1;
        bc_key_d   = ram_rdata;
        bc_frame_d = p_frame_q;
      end
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d    = op_e'(s_axis_tuser);
          frame_d = s_axis_tdata[5:0];
          mark_d  = s_axis_tdata[6];
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_valid_d = 1'b0;
        res_frame_d = '0;
        state_d     = ST_DONE;
        // Access stamps then advances; the other operations advance first.
        if (op_q != OP_ACCESS || (in_range && {1'b0, frame_q} < active_q)) begin
          if (stamp_q != {STAMP_BITS{1'b1}}) begin
            stamp_d = stamp_q + 1'b1;
          end
        end
        case (op_q)
          OP_ACCESS: begin
            if (in_range && {1'b0, frame_q} < active_q) begin
              ram_we     = 1'b1;
              sel[f_idx] = 1'b1;
              cmd.kind   = CMD_ACCESS;
            end
          end
          OP_SETEV: begin
            if (in_range && cur.tracked) begin
              sel[f_idx] = 1'b1;
              cmd.kind   = mark_q ? CMD_SET : CMD_CLEAR;
              if (mark_q && !cur.evictable) begin
                cnt_d = cnt_q + 1'b1;
              end else if (!mark_q && cur.evictable) begin
                cnt_d = cnt_q - 1'b1;
              end
            end
          end
          OP_REMOVE: begin
            if (in_range) begin
              sel[f_idx] = 1'b1;
              cmd.kind   = CMD_UNTRACK;
              if (cur.evictable) begin
                cnt_d = cnt_q - 1'b1;
              end
            end
          end
          default: begin
            bh_found_d = 1'b0;
            bc_found_d = 1'b0;
            scan_d     = '0;
            state_d    = ST_SCAN;
          end
        endcase
      end
      ST_SCAN: begin
        shift     = 1'b1;
        p_valid_d = head.tracked && head.evictable;
        scan_d    = scan_q + 1'b1;
        if (scan_q == FW'(N_FRAMES - 1)) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        res_valid_d = found;
        res_frame_d = found ? victim : '0;
        if (found) begin
          sel[victim] = 1'b1;
          cmd.kind    = CMD_UNTRACK;
          cnt_d       = cnt_q - 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (can_out) begin
          out_valid_d = 1'b1;
          out_data_d  = {2'b00, cnt_q[6:0], victim_x[5:0], res_valid_q};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stamp_q     <= '0;
      cnt_q       <= '0;
      scan_q      <= '0;
      p_valid_q   <= 1'b0;
      bh_found_q  <= 1'b0;
      bc_found_q  <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stamp_q     <= stamp_d;
      cnt_q       <= cnt_d;
      scan_q      <= scan_d;
      p_valid_q   <= p_valid_d;
      bh_found_q  <= bh_found_d;
      bc_found_q  <= bc_found_d;
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    frame_q     <= frame_d;
    mark_q      <= mark_d;
    p_hist_q    <= p_hist_d;
    p_frame_q   <= p_frame_d;
    bh_key_q    <= bh_key_d;
    bh_frame_q  <= bh_frame_d;
    bc_key_q    <= bc_key_d;
    bc_frame_q  <= bc_frame_d;
    res_frame_q <= res_frame_d;
    out_data_q  <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `LKR_ASSERT(a_cnt_bound, cnt_q <= CW'(N_FRAMES), "evictable count exceeds frame count")
  `LKR_ASSERT_IMP(a_scan_only_in_scan, p_valid_q, $past(state_q == ST_SCAN), "stray compare")
  `LKR_ASSERT_IMP(a_out_from_done, $rose(out_valid_q), $past(state_q == ST_DONE), "stray result")

endmodule

FILE: src/lkr_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module lkr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/lkr_cell.sv
// ---------------------------------------------------------------------------
// LRU-K replacer frame cell
// Holds one frame's bookkeeping; shifts to its neighbor during a scan.
// ---------------------------------------------------------------------------
module lkr_cell import lkr_pkg::*; #(
  parameter int MAX_K = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      shift_i,
  input  cell_t     nb_i,
  input  logic      sel_i,
  input  cell_cmd_t cmd_i,
  output cell_t     state_o
);

  cell_t state_q, state_d, base;

  always_comb begin
    base    = state_q;
    state_d = state_q;
    if (!state_q.tracked) begin
      base.in_cache = 1'b0;
      base.tally    = '0;
      base.head     = '0;
    end
    if (shift_i) begin
      state_d = nb_i;
    end else if (sel_i) begin
      case (cmd_i.kind)
        CMD_ACCESS: begin
          state_d         = base;
          state_d.tracked = 1'b1;
          state_d.head    = (base.head == HEAD_W'(MAX_K - 1)) ? '0 : base.head + 1'b1;
          if (!base.in_cache) begin
            if (base.tally < TALLY_W'(MAX_K)) begin
              state_d.tally = base.tally + 1'b1;
            end
            state_d.in_cache = (state_d.tally >= cmd_i.keff);
          end
        end
        CMD_SET:     state_d.evictable = state_q.tracked;
        CMD_CLEAR:   state_d.evictable = 1'b0;
        CMD_UNTRACK: state_d = '0;
        default:     state_d = state_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

FILE: verif/tb_lru_k_frame_replacer_core.sv
// ---------------------------------------------------------------------------
// LRU-K frame replacer core testbench
// Drives operation streams through the replacer under several settings of
// active frames and k, predicts every result with a behavioral replacer and
// compares each output transfer field by field, with random idling on both
// sides and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_lru_k_frame_replacer_core import lkr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFR       = 64;
  localparam int KMAX      = 8;
  localparam int SETTLE    = 100;   // Longer than an evict pass through all NFR frames.
  localparam int STALL_LEN = 300;
  localparam int DOG_LIMIT = 5000;
  localparam int DUE_DEPTH = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;

  lru_k_frame_replacer_core dut (.*);

  // One expected result, packed as it appears on the output bus.
  typedef struct packed {
    logic [6:0] count;
    logic [5:0] frame;
    logic       valid;
  } verdict_t;

  // Expected results in order, kept in a small ring with running counters.
  verdict_t verdicts_due[DUE_DEPTH];
  int       due_wr = 0;
  int       due_rd = 0;
  int       fail_cnt = 0;
  bit       steady = 1'b0;     // Suppresses idling on both sides.
  bit       stall_req = 1'b0;  // Asks the receiver for one long hold-off.

  // Replacer state as the block should hold it.
  logic [47:0] stamp_now;
  bit          trk[NFR], in_cache[NFR], evb[NFR];
  logic [3:0]  tally[NFR];
  logic [2:0]  head[NFR];
  logic [47:0] ring[NFR][KMAX];
  logic [6:0]  ev_total;
  logic [6:0]  act_frames;
  logic [3:0]  k_reg;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void advance_stamp();
    if (stamp_now != '1) stamp_now = stamp_now + 1;
  endfunction

  function automatic void drop_frame(int f);
    if (evb[f]) ev_total = ev_total - 1;
    trk[f] = 1'b0;
    in_cache[f] = 1'b0;
    evb[f] = 1'b0;
    tally[f] = '0;
    head[f] = '0;
  endfunction

  // Oldest kept stamp in the history class; in the cache class the tally-th most recent, the k-th unless k changed.
  function automatic logic [47:0] frame_key(int f);
    logic [2:0] idx;
    idx = head[f] - tally[f][2:0];
    return ring[f][idx];
  endfunction

  function automatic bit pick_victim(bit want_cache, output int victim);
    bit          found;
    logic [47:0] best;
    found = 1'b0;
    best = '0;
    victim = 0;
    for (int f = 0; f < NFR; f++) begin
      if (trk[f] && evb[f] && in_cache[f] == want_cache) begin
        if (!found || frame_key(f) < best) begin
          found = 1'b1;
          best = frame_key(f);
          victim = f;
        end
      end
    end
    return found;
  endfunction

  // Applies one operation to the replacer state and returns its result.
  function automatic verdict_t replacer_step(op_e op, int f, bit mark);
    verdict_t   r;
    int         victim;
    logic [4:0] keff;
    r = '0;
    keff = (k_reg == 0) ? 5'd1 : (k_reg > KMAX) ? 5'(KMAX) : 5'(k_reg);
    case (op)
      OP_ACCESS: begin
        if (f < act_frames) begin
          if (!trk[f]) begin
            trk[f] = 1'b1;
            in_cache[f] = 1'b0;
            tally[f] = '0;
            head[f] = '0;
          end
          ring[f][head[f]] = stamp_now;
          head[f] = head[f] + 1;
          if (!in_cache[f]) begin
            if (tally[f] < KMAX) tally[f] = tally[f] + 1;
            if (5'(tally[f]) >= keff) in_cache[f] = 1'b1;
          end
          advance_stamp();
        end
      end
      OP_SETEV: begin
        advance_stamp();
        if (trk[f]) begin
          if (mark && !evb[f]) begin
            evb[f] = 1'b1;
            ev_total = ev_total + 1;
          end else if (!mark && evb[f]) begin
            evb[f] = 1'b0;
            ev_total = ev_total - 1;
          end
        end
      end
      OP_REMOVE: begin
        advance_stamp();
        drop_frame(f);
      end
      default: begin
        advance_stamp();
        r.valid = pick_victim(1'b0, victim);
        if (!r.valid) r.valid = pick_victim(1'b1, victim);
        if (r.valid) begin
          drop_frame(victim);
          r.frame = 6'(victim);
        end
      end
    endcase
    r.count = ev_total;
    return r;
  endfunction

  // Offers one operation, waits for its transfer and records the prediction.
  // The valid line is only lowered inside a gap, so it never toggles within
  // one time step between back-to-back operations.
  task automatic send_op(op_e op, int f, bit mark = 1'b0);
    if (!steady && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, mark, 6'(f)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    verdicts_due[due_wr % DUE_DEPTH] = replacer_step(op, f, mark);
    due_wr++;
  endtask

  // Lets the block run dry: every result back, plus a settling pause.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (due_wr != due_rd) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Writes both registers while the block is idle.
  task automatic set_config(int act, int k);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ACTIVE;
    cfg_wdata_i <= 7'(act);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_K;
    cfg_wdata_i <= 7'(k);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    act_frames = 7'(act);
    k_reg = 4'(k);
  endtask

  // Random operations weighted toward reuse of a small set of frames, so that
  // frames climb into the cache class and evictions find real victims.
  task automatic random_ops(int n, int span);
    int pick, f;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      f = ($urandom_range(9) == 0) ? $urandom_range(NFR - 1) : $urandom_range(span - 1);
      if (pick < 45)      send_op(OP_ACCESS, f);
      else if (pick < 70) send_op(OP_SETEV, f, $urandom_range(4) != 0);
      else if (pick < 78) send_op(OP_REMOVE, f);
      else                send_op(OP_EVICT, $urandom_range(NFR - 1), $urandom_range(1));
    end
  endtask

  // Extremes of the fields, every operation and the special cases.
  task automatic test_directed();
    set_config(64, 2);
    send_op(OP_EVICT, 0);            // Nothing to evict yet.
    send_op(OP_SETEV, 5, 1'b1);      // Untracked frame: marking is ignored.
    send_op(OP_SETEV, 5, 1'b0);      // Untracked frame: clearing is harmless.
    send_op(OP_REMOVE, 63);          // Untracked frame: remove is harmless.
    send_op(OP_ACCESS, 63);
    send_op(OP_ACCESS, 0);
    send_op(OP_ACCESS, 63);          // Second access: joins the cache class.
    send_op(OP_ACCESS, 7);
    send_op(OP_SETEV, 63, 1'b1);
    send_op(OP_SETEV, 0, 1'b1);
    send_op(OP_SETEV, 7, 1'b1);
    send_op(OP_SETEV, 7, 1'b1);      // Already marked.
    send_op(OP_EVICT, 63);           // History class wins: frame 0.
    send_op(OP_EVICT, 0);            // Then frame 7.
    send_op(OP_EVICT, 0);            // Then the cache frame 63.
    send_op(OP_ACCESS, 9);
    send_op(OP_SETEV, 9, 1'b1);
    send_op(OP_REMOVE, 9);           // Removes an evictable frame.
    send_op(OP_ACCESS, 10);
    send_op(OP_REMOVE, 10);          // Removes a frame that is not evictable.
    set_config(1, 1);
    send_op(OP_ACCESS, 1);           // Beyond the active frames: ignored.
    send_op(OP_ACCESS, 63);          // Ignored as well.
    send_op(OP_ACCESS, 0);
    send_op(OP_SETEV, 0, 1'b1);
    send_op(OP_EVICT, 0);
  endtask

  // A tally built under a large k stays when k is lowered.
  task automatic test_lowered_k();
    set_config(64, 8);
    for (int f = 0; f < 6; f++) begin
      repeat (3) send_op(OP_ACCESS, f);
      send_op(OP_SETEV, f, 1'b1);
    end
    set_config(64, 2);
    for (int f = 0; f < 6; f += 2) send_op(OP_ACCESS, f);
    repeat (7) send_op(OP_EVICT, 0);
  endtask

  // Out-of-range k values and the random sweep across settings.
  task automatic test_random_sweep();
    set_config(64, 2);
    steady = 1'b1;                   // A long stretch with no idling at all.
    random_ops(150, 12);
    steady = 1'b0;
    set_config(64, 0);
    random_ops(130, 10);
    set_config(8, 15);
    random_ops(130, 10);
    set_config(16, 8);
    random_ops(150, 16);
    set_config(40, 3);
    random_ops(130, 20);
    set_config(1, 1);
    random_ops(60, 2);
    set_config(64, 1);
    random_ops(181, 64);
  endtask

  // The receiver holds off while operations keep coming, so the block backs up.
  task automatic test_output_stall();
    set_config(64, 4);
    stall_req = 1'b1;
    random_ops(40, 8);
    random_ops(20, 8);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        m_axis_tready <= 1'b0;
        repeat (STALL_LEN) @(posedge clk_i);
        stall_req = 1'b0;
      end else begin
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 16);
      end
    end
  end

  // Compares each output transfer with the oldest prediction.
  always @(posedge clk_i) begin
    verdict_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = verdict_t'(m_axis_tdata[13:0]);
      if (due_wr == due_rd) begin
        $error("unexpected result transfer: %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = verdicts_due[due_rd % DUE_DEPTH];
        due_rd++;
        if (got.valid !== want.valid) begin
          $error("evicted_valid: expected %0d, actual %0d", want.valid, got.valid);
          fail_cnt++;
        end
        if (got.frame !== want.frame) begin
          $error("evicted_frame: expected %0d, actual %0d", want.frame, got.frame);
          fail_cnt++;
        end
        if (got.count !== want.count) begin
          $error("evictable_count: expected %0d, actual %0d", want.count, got.count);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= DOG_LIMIT) begin
        $display("** lru_k_frame_replacer_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    stamp_now = '0;
    ev_total = '0;
    act_frames = 7'd64;
    k_reg = 4'd2;
    for (int f = 0; f < NFR; f++) begin
      trk[f] = 1'b0;
      in_cache[f] = 1'b0;
      evb[f] = 1'b0;
      tally[f] = '0;
      head[f] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_lowered_k();
    test_output_stall();
    test_random_sweep();
    drain();
    if (fail_cnt == 0) begin
      $display("** lru_k_frame_replacer_core: PASSED **");
    end else begin
      $display("** lru_k_frame_replacer_core: FAILED **");
    end
    $finish;
  end

endmodule
